// ===== rtl/core/tct_pkg.sv =====
// Shared types and constants for the text-cell terminal controller.
// Used by tct_ctrl, tct_datapath and the top level; depends on nothing.
package tct_pkg;

   // Default store geometry
   localparam int unsigned MAX_ROWS_DEF = 64;
   localparam int unsigned MAX_COLS_DEF = 256;

   // Register reset values
   localparam logic [6:0]  ROWS_RESET  = 7'd50;
   localparam logic [8:0]  COLS_RESET  = 9'd160;
   localparam logic [15:0] BLINK_RESET = 16'd30;

   // Blank cell: character zero, white on black
   localparam logic [7:0]  BLANK_CHAR = 8'h00;
   localparam logic [31:0] BLANK_FG   = 32'h00FF_FFFF;
   localparam logic [31:0] BLANK_BG   = 32'h0000_0000;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned COLOUR_W = 64;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_BLINK = 2'd2
   } csr_index_type;

   // Operation codes
   typedef enum logic [2:0] {
      FUNC_PUT     = 3'd0,
      FUNC_NEWLINE = 3'd1,
      FUNC_ERASE   = 3'd2,
      FUNC_CLEAR   = 3'd3,
      FUNC_BLINK   = 3'd4,
      FUNC_READ    = 3'd5
   } func_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_BLANK,
      ST_ERASE,
      ST_CLEAR,
      ST_READ,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic blank_step;
      logic erase_step;
      logic clear_step;
      logic read_capture;
      logic load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scroll_now;
      logic erase_run;
      logic blank_last;
      logic erase_end;
      logic sweep_last;
   } status_type;

endpackage

// ===== rtl/core/text_cell_terminal_controller.sv =====
// Text-cell terminal controller top level; uses tct_pkg, tct_ctrl and tct_datapath.
// Put char, newline, blink, unused codes and zero erase load the result register on accept; a
// scroll first blanks the new bottom row, erase blanks cells back from the cursor until its count
// runs out or home, read captures the cell, clear sweeps the store. One item a cycle unless stalled.
// Synchronous reset: the stores are then swept to blank, one entry a cycle (16384 entries at the
// default size), with req_stall held high; configuration writes are taken throughout.
module text_cell_terminal_controller #(
   parameter int unsigned MAX_ROWS = tct_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS = tct_pkg::MAX_COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // Request items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_fg_colour,
   input  logic [31:0] req_bg_colour,
   input  logic [7:0]  req_erase_count,
   input  logic [5:0]  req_read_row,
   input  logic [7:0]  req_read_col,
   // Result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_cursor_row_out,
   output logic [7:0]  rsp_cursor_col_out,
   output logic        rsp_cursor_on,
   output logic        rsp_scrolled,
   output logic [7:0]  rsp_cell_char,
   output logic [31:0] rsp_cell_fg,
   output logic [31:0] rsp_cell_bg
);

   tct_pkg::cmd_type    cmd;
   tct_pkg::status_type status;
   logic                csr_wr;

   // Registers are always writable
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   tct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tct_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr             (csr_wr),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_fg_colour      (req_fg_colour),
      .req_bg_colour      (req_bg_colour),
      .req_erase_count    (req_erase_count),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cursor_on      (rsp_cursor_on),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_fg        (rsp_cell_fg),
      .rsp_cell_bg        (rsp_cell_bg)
   );

endmodule

// ===== rtl/core/tct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module tct_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tct_ctrl.sv =====
// Sequencer for the terminal controller: handshakes, walks and result hand-off.
// Depends on tct_pkg for state, command and status types.
module tct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_func,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tct_pkg::status_type status,
   output tct_pkg::cmd_type    cmd
);

   tct_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tct_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = 1'b1;
      case (state_ff)
         tct_pkg::ST_INIT: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = tct_pkg::ST_IDLE;
            end
         end
         tct_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               cmd.start = 1'b1;
               case (req_func)
                  tct_pkg::FUNC_PUT, tct_pkg::FUNC_NEWLINE: begin
                     if (status.scroll_now) begin
                        state_in = tct_pkg::ST_BLANK;
                     end else begin
                        cmd.load = 1'b1;
                     end
                  end
                  tct_pkg::FUNC_ERASE: begin
                     if (status.erase_run) begin
                        state_in = tct_pkg::ST_ERASE;
                     end else begin
                        cmd.load = 1'b1;
                     end
                  end
                  tct_pkg::FUNC_CLEAR: begin
                     state_in = tct_pkg::ST_CLEAR;
                  end
                  tct_pkg::FUNC_READ: begin
                     state_in = tct_pkg::ST_READ;
                  end
                  default: begin
                     cmd.load = 1'b1;
                  end
               endcase
            end
         end
         tct_pkg::ST_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.blank_last) begin
               state_in = tct_pkg::ST_DONE;
            end
         end
         tct_pkg::ST_ERASE: begin
            if (status.erase_end) begin
               state_in = tct_pkg::ST_DONE;
            end else begin
               cmd.erase_step = 1'b1;
            end
         end
         tct_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = tct_pkg::ST_DONE;
            end
         end
         tct_pkg::ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in         = tct_pkg::ST_DONE;
         end
         tct_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = tct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tct_pkg::ST_IDLE;
         end
      endcase
      // Hold the result until taken
      rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tct_datapath.sv =====
// Datapath of the terminal controller: registers, cursor arithmetic, cell stores.
// Depends on tct_pkg and tct_ram.
module tct_datapath #(
   parameter int unsigned MAX_ROWS = tct_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS = tct_pkg::MAX_COLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tct_pkg::cmd_type    cmd,
   output tct_pkg::status_type status,
   input  logic                csr_wr,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic [2:0]          req_func,
   input  logic [7:0]          req_char_code,
   input  logic [31:0]         req_fg_colour,
   input  logic [31:0]         req_bg_colour,
   input  logic [7:0]          req_erase_count,
   input  logic [5:0]          req_read_row,
   input  logic [7:0]          req_read_col,
   output logic [5:0]          rsp_cursor_row_out,
   output logic [7:0]          rsp_cursor_col_out,
   output logic                rsp_cursor_on,
   output logic                rsp_scrolled,
   output logic [7:0]          rsp_cell_char,
   output logic [31:0]         rsp_cell_fg,
   output logic [31:0]         rsp_cell_bg
);

   localparam int unsigned RW       = $clog2(MAX_ROWS);
   localparam int unsigned CW       = $clog2(MAX_COLS);
   localparam int unsigned RCW      = $clog2(MAX_ROWS + 1);
   localparam int unsigned CCW      = $clog2(MAX_COLS + 1);
   localparam int unsigned AW       = RW + CW;
   localparam int unsigned DEPTH    = 2 ** AW;
   localparam int unsigned CHAR_W_L = tct_pkg::CHAR_W;
   localparam int unsigned COL_W_L  = tct_pkg::COLOUR_W;

   // Store row of a screen row under the ring offset
   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                              input logic [RW-1:0] row);
      logic [RW:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (RW+1)'(MAX_ROWS)) begin
         sum = sum - (RW+1)'(MAX_ROWS);
      end
      return sum[RW-1:0];
   endfunction

   // Configuration registers
   logic [6:0]  rows_cfg_ff;
   logic [8:0]  cols_cfg_ff;
   logic [15:0] period_ff;

   // Control state
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] top_ff, top_in;
   logic [15:0]   blink_count_ff, blink_count_in;
   logic          phase_ff, phase_in;
   logic          scrolled_ff, scrolled_in;
   logic [7:0]    erase_left_ff, erase_left_in;
   logic [CW-1:0] blank_col_ff, blank_col_in;
   logic [AW-1:0] sweep_ff;
   logic          read_ok_ff, read_ok_in;

   // Payload registers
   logic [7:0]  cell_char_ff, cell_char_in;
   logic [31:0] cell_fg_ff, cell_fg_in;
   logic [31:0] cell_bg_ff, cell_bg_in;
   logic [5:0]  rsp_row_ff;
   logic [7:0]  rsp_col_ff;
   logic        rsp_on_ff;
   logic        rsp_scrolled_ff;
   logic [7:0]  rsp_char_ff;
   logic [31:0] rsp_fg_ff;
   logic [31:0] rsp_bg_ff;

   // Derived values
   logic [RCW-1:0] rows_eff, rows_m1;
   logic [CCW-1:0] cols_eff, cols_m1;
   logic [RW-1:0]  row_c, row_next, top_inc, erow;
   logic [CW-1:0]  col_c, ecol;
   logic           row_hit, col_hit;
   logic [RW-1:0]  rrow;
   logic [CW-1:0]  rcol;
   logic           read_ok_now;

   // Store ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [CHAR_W_L-1:0]   wr_char;
   logic [COL_W_L-1:0]    wr_colour;
   logic [CHAR_W_L-1:0]   rd_char;
   logic [COL_W_L-1:0]    rd_colour;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= tct_pkg::ROWS_RESET;
         cols_cfg_ff <= tct_pkg::COLS_RESET;
         period_ff   <= tct_pkg::BLINK_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            tct_pkg::CSR_ROWS:  rows_cfg_ff <= csr_wdata[6:0];
            tct_pkg::CSR_COLS:  cols_cfg_ff <= csr_wdata[8:0];
            tct_pkg::CSR_BLINK: period_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp the screen size into the store
   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_eff = CCW'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = CCW'(cols_cfg_ff);
      end
      rows_m1 = rows_eff - RCW'(1);
      cols_m1 = cols_eff - CCW'(1);
   end

   // Clamp the cursor and work out where it moves
   always_comb begin
      row_c    = (RCW'(cur_row_ff) >= rows_eff) ? RW'(rows_m1) : cur_row_ff;
      col_c    = (CCW'(cur_col_ff) >= cols_eff) ? CW'(cols_m1) : cur_col_ff;
      row_hit  = (RCW'(row_c) + RCW'(1)) >= rows_eff;
      col_hit  = (CCW'(col_c) + CCW'(1)) >= cols_eff;
      row_next = row_c + RW'(1);
      top_inc  = (top_ff == RW'(MAX_ROWS - 1)) ? '0 : top_ff + RW'(1);
      // One cell back for erase
      if (cur_col_ff == '0) begin
         ecol = CW'(cols_m1);
         erow = cur_row_ff - RW'(1);
      end else begin
         ecol = cur_col_ff - CW'(1);
         erow = cur_row_ff;
      end
      rrow        = RW'(req_read_row);
      rcol        = CW'(req_read_col);
      read_ok_now = (32'(req_read_row) < 32'(rows_eff)) &&
                    (32'(req_read_col) < 32'(cols_eff));
   end

   // Status to the controller
   always_comb begin
      status            = '0;
      status.scroll_now = row_hit && ((req_func == tct_pkg::FUNC_NEWLINE) ||
                                      ((req_func == tct_pkg::FUNC_PUT) && col_hit));
      status.erase_run  = req_erase_count != '0;
      status.blank_last = CCW'(blank_col_ff) == cols_m1;
      status.erase_end  = (erase_left_ff == '0) ||
                          ((cur_row_ff == '0) && (cur_col_ff == '0));
      status.sweep_last = sweep_ff == '1;
   end

   // Store write port
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = sweep_ff;
      wr_char   = tct_pkg::BLANK_CHAR;
      wr_colour = {tct_pkg::BLANK_FG, tct_pkg::BLANK_BG};
      if (cmd.start && (req_func == tct_pkg::FUNC_PUT)) begin
         wr_en     = 1'b1;
         wr_addr   = {phys_row(top_ff, row_c), col_c};
         wr_char   = req_char_code;
         wr_colour = {req_fg_colour, req_bg_colour};
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
         wr_addr = {phys_row(top_ff, cur_row_ff), blank_col_ff};
      end else if (cmd.erase_step) begin
         wr_en   = 1'b1;
         wr_addr = {phys_row(top_ff, erow), ecol};
      end else if (cmd.clear_step) begin
         wr_en = 1'b1;
      end
   end

   assign rd_addr = {phys_row(top_ff, rrow), rcol};

   // Next state of cursor, timer and walks
   always_comb begin
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      top_in         = top_ff;
      blink_count_in = blink_count_ff;
      phase_in       = phase_ff;
      scrolled_in    = scrolled_ff;
      erase_left_in  = erase_left_ff;
      blank_col_in   = blank_col_ff;
      read_ok_in     = read_ok_ff;
      cell_char_in   = cell_char_ff;
      cell_fg_in     = cell_fg_ff;
      cell_bg_in     = cell_bg_ff;
      if (cmd.start) begin
         cur_row_in   = row_c;
         cur_col_in   = col_c;
         scrolled_in  = 1'b0;
         blank_col_in = '0;
         cell_char_in = '0;
         cell_fg_in   = '0;
         cell_bg_in   = '0;
         case (req_func)
            tct_pkg::FUNC_PUT, tct_pkg::FUNC_NEWLINE: begin
               if (col_hit || (req_func == tct_pkg::FUNC_NEWLINE)) begin
                  cur_col_in = '0;
                  if (row_hit) begin
                     top_in      = top_inc;
                     scrolled_in = 1'b1;
                  end else begin
                     cur_row_in = row_next;
                  end
               end else begin
                  cur_col_in = col_c + CW'(1);
               end
            end
            tct_pkg::FUNC_ERASE: begin
               erase_left_in = req_erase_count;
            end
            tct_pkg::FUNC_CLEAR: begin
               cur_row_in = '0;
               cur_col_in = '0;
               top_in     = '0;
            end
            tct_pkg::FUNC_BLINK: begin
               if (blink_count_ff == period_ff) begin
                  blink_count_in = '0;
                  phase_in       = !phase_ff;
               end else begin
                  blink_count_in = blink_count_ff + 16'd1;
               end
            end
            tct_pkg::FUNC_READ: begin
               read_ok_in = read_ok_now;
            end
            default: begin
            end
         endcase
      end
      if (cmd.blank_step) begin
         blank_col_in = blank_col_ff + CW'(1);
      end
      if (cmd.erase_step) begin
         cur_row_in    = erow;
         cur_col_in    = ecol;
         erase_left_in = erase_left_ff - 8'd1;
      end
      // Take the cell, or zeros off screen
      if (cmd.read_capture && read_ok_ff) begin
         cell_char_in = rd_char;
         cell_fg_in   = rd_colour[63:32];
         cell_bg_in   = rd_colour[31:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff     <= '0;
         cur_col_ff     <= '0;
         top_ff         <= '0;
         blink_count_ff <= '0;
         phase_ff       <= 1'b1;
         scrolled_ff    <= 1'b0;
         erase_left_ff  <= '0;
         blank_col_ff   <= '0;
         sweep_ff       <= '0;
         read_ok_ff     <= 1'b0;
      end else begin
         cur_row_ff     <= cur_row_in;
         cur_col_ff     <= cur_col_in;
         top_ff         <= top_in;
         blink_count_ff <= blink_count_in;
         phase_ff       <= phase_in;
         scrolled_ff    <= scrolled_in;
         erase_left_ff  <= erase_left_in;
         blank_col_ff   <= blank_col_in;
         read_ok_ff     <= read_ok_in;
         if (cmd.clear_step) begin
            sweep_ff <= sweep_ff + AW'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cell_char_ff <= cell_char_in;
      cell_fg_ff   <= cell_fg_in;
      cell_bg_ff   <= cell_bg_in;
      if (cmd.load) begin
         rsp_row_ff      <= 6'(cur_row_in);
         rsp_col_ff      <= 8'(cur_col_in);
         rsp_on_ff       <= phase_in;
         rsp_scrolled_ff <= scrolled_in;
         rsp_char_ff     <= cell_char_in;
         rsp_fg_ff       <= cell_fg_in;
         rsp_bg_ff       <= cell_bg_in;
      end
   end

   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_cursor_on      = rsp_on_ff;
   assign rsp_scrolled       = rsp_scrolled_ff;
   assign rsp_cell_char      = rsp_char_ff;
   assign rsp_cell_fg        = rsp_fg_ff;
   assign rsp_cell_bg        = rsp_bg_ff;

   // Character store
   tct_ram #(
      .WIDTH (CHAR_W_L),
      .DEPTH (DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_char),
      .rd_addr (rd_addr),
      .rd_data (rd_char)
   );

   // Colour store: foreground high, background low
   tct_ram #(
      .WIDTH (COL_W_L),
      .DEPTH (DEPTH)
   ) u_colour_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_colour),
      .rd_addr (rd_addr),
      .rd_data (rd_colour)
   );

endmodule
